// File: design/assert_macros.svh
// Assertion macros shared by the edge suppression RTL.
// Include by bare file name; each macro names its own label.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: design/enms_pkg.sv
// Package for the edge non-maximum suppression block.
// Holds register indexes, angle sector constants and the sector decoder.
package enms_pkg;

   // Configuration register indexes
   localparam logic [1:0] REG_ROW_LENGTH = 2'd0;
   localparam logic [1:0] REG_ROW_COUNT  = 2'd1;

   localparam logic [10:0] ROW_LENGTH_RESET = 11'd640;
   localparam logic [10:0] ROW_COUNT_RESET  = 11'd480;
   localparam int          MIN_LEN          = 3;

   // Sector boundaries in whole degrees
   localparam logic signed [9:0] ANG_0   = 10'sd0;
   localparam logic signed [9:0] ANG_45  = 10'sd45;
   localparam logic signed [9:0] ANG_90  = 10'sd90;
   localparam logic signed [9:0] ANG_135 = 10'sd135;
   localparam logic signed [9:0] ANG_180 = 10'sd180;
   localparam logic signed [9:0] ANG_225 = 10'sd225;
   localparam logic signed [9:0] ANG_270 = 10'sd270;
   localparam logic signed [9:0] ANG_315 = 10'sd315;
   localparam logic signed [9:0] ANG_360 = 10'sd360;

   // Neighbour pair picked for a centre pixel
   typedef enum logic [2:0] {
      SEC_NONE,   // angle out of range
      SEC_HORZ,   // left and right
      SEC_DIAG,   // up-left and down-right
      SEC_VERT,   // up and down
      SEC_ANTI    // down-left and up-right
   } sector_type;

   // Map an angle to its neighbour pair, the 135..179 span taking the diagonal
   function automatic sector_type angle_sector(input logic signed [9:0] ang);
      sector_type sec;
      if (ang < ANG_0 || ang > ANG_360) sec = SEC_NONE;
      else if (ang < ANG_45)            sec = SEC_HORZ;
      else if (ang < ANG_90)            sec = SEC_DIAG;
      else if (ang < ANG_135)           sec = SEC_VERT;
      else if (ang < ANG_180)           sec = SEC_DIAG;
      else if (ang < ANG_225)           sec = SEC_HORZ;
      else if (ang < ANG_270)           sec = SEC_ANTI;
      else if (ang < ANG_315)           sec = SEC_VERT;
      else                              sec = SEC_DIAG;
      return sec;
   endfunction

endpackage

// File: design/enms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies; contents are not reset.
module enms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write on enable, read into the output register on enable
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: design/edge_nonmax_suppression.sv
// Edge non-maximum suppression: accepted beats pass stage 1, then the result register.
// 1 pixel per cycle unless stalled, set by the single read and write port of each line RAM.
// Results for row 0, column 0, the last row and the last column are dropped or zeroed.
// Synchronous reset clears position counters, window, centre angle and valid flags;
// line store RAMs are not cleared and hold undefined data until written.
`include "assert_macros.svh"

module edge_nonmax_suppression #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAG_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input beats: [15:0] magnitude, [25:16] angle, [31:26] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // Result beats: [15:0] kept_value, [25:16] out_row, [35:26] out_col, [39:36] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,     // frame_end
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);

   import enms_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int CMP_W = 14;

   // Configuration registers
   logic [10:0] row_length_ff, row_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RESET;
         row_count_ff  <= ROW_COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ROW_LENGTH: row_length_ff <= csr_data;
            REG_ROW_COUNT:  row_count_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Clamp the frame geometry between MIN_LEN and what the stores hold
   logic [CMP_W-1:0] len, cnt, len_raw, cnt_raw;

   always_comb begin
      len_raw = CMP_W'(row_length_ff);
      cnt_raw = CMP_W'(row_count_ff);
      if (len_raw < CMP_W'(MIN_LEN))        len = CMP_W'(MIN_LEN);
      else if (len_raw > CMP_W'(MAX_WIDTH)) len = CMP_W'(MAX_WIDTH);
      else                                  len = len_raw;
      if (cnt_raw < CMP_W'(MIN_LEN))         cnt = CMP_W'(MIN_LEN);
      else if (cnt_raw > CMP_W'(MAX_HEIGHT)) cnt = CMP_W'(MAX_HEIGHT);
      else                                   cnt = cnt_raw;
   end

   // Handshake control
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic s1_adv, req_acc;

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;

   // Position of the incoming pixel
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             col_last, row_last;

   assign col_last = (CMP_W'(col_ff) + CMP_W'(1)) >= len;
   assign row_last = (CMP_W'(row_ff) + CMP_W'(1)) >= cnt;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_acc) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // Stage 1: pixel and bookkeeping while the line stores are read
   logic [MAG_BITS-1:0]  s1_mag_ff;
   logic signed [9:0]    s1_ang_ff;
   logic [COL_W-1:0]     s1_col_ff;
   logic                 s1_emit_ff, s1_inner_ff, s1_last_ff;
   logic [9:0]           s1_orow_ff, s1_ocol_ff;

   assign s1_valid_in = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_mag_ff   <= MAG_BITS'(req_tdata[15:0]);
         s1_ang_ff   <= req_tdata[25:16];
         s1_col_ff   <= col_ff;
         s1_emit_ff  <= (row_ff >= ROW_W'(1)) && (col_ff >= COL_W'(1));
         s1_inner_ff <= (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
         s1_last_ff  <= row_last && col_last;
         s1_orow_ff  <= 10'(row_ff - 1'b1);
         s1_ocol_ff  <= 10'(col_ff - 1'b1);
      end
   end

   // Line stores: two magnitude lines packed in one word, one angle line
   logic [2*MAG_BITS-1:0] mag_rd;
   logic [9:0]            ang_rd;

   enms_ram #(.WIDTH(2*MAG_BITS), .DEPTH(MAX_WIDTH)) u_mag_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data ({mag_rd[MAG_BITS-1:0], s1_mag_ff}),
      .rd_en   (req_acc),
      .rd_addr (col_ff),
      .rd_data (mag_rd)
   );

   enms_ram #(.WIDTH(10), .DEPTH(MAX_WIDTH)) u_ang_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (s1_ang_ff),
      .rd_en   (req_acc),
      .rd_addr (col_ff),
      .rd_data (ang_rd)
   );

   // Window shift: next window with the new column on the right
   logic [MAG_BITS-1:0] win_ff [3][3];
   logic [MAG_BITS-1:0] win_in [3][3];
   logic signed [9:0]   cang_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][1];
         win_in[k][1] = win_ff[k][2];
      end
      win_in[0][2] = mag_rd[2*MAG_BITS-1:MAG_BITS];
      win_in[1][2] = mag_rd[MAG_BITS-1:0];
      win_in[2][2] = s1_mag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= '0;
            end
         end
         cang_ff <= '0;
      end else if (s1_adv) begin
         win_ff  <= win_in;
         cang_ff <= ang_rd;
      end
   end

   // Suppress: keep the centre of an inner window if it is at least both neighbours
   sector_type          sec;
   logic [MAG_BITS-1:0] ctr, nb1, nb2, kept;

   always_comb begin
      sec = angle_sector(cang_ff);
      ctr = win_in[1][1];
      case (sec)
         SEC_HORZ: begin
            nb1 = win_in[1][0];
            nb2 = win_in[1][2];
         end
         SEC_DIAG: begin
            nb1 = win_in[0][0];
            nb2 = win_in[2][2];
         end
         SEC_VERT: begin
            nb1 = win_in[0][1];
            nb2 = win_in[2][1];
         end
         SEC_ANTI: begin
            nb1 = win_in[2][0];
            nb2 = win_in[0][2];
         end
         default: begin
            nb1 = '0;
            nb2 = '0;
         end
      endcase
      if (s1_inner_ff && sec != SEC_NONE && ctr >= nb1 && ctr >= nb2) kept = ctr;
      else                                                            kept = '0;
   end

   // Result register
   logic [15:0] kept_ff;
   logic [9:0]  orow_ff, ocol_ff;
   logic        last_ff;

   always_comb begin
      if (s1_adv && s1_emit_ff) out_valid_in = 1'b1;
      else if (rsp_tready)      out_valid_in = 1'b0;
      else                      out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit_ff) begin
         kept_ff <= 16'(kept);
         orow_ff <= s1_orow_ff;
         ocol_ff <= s1_ocol_ff;
         last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, ocol_ff, orow_ff, kept_ff};
   assign rsp_tlast  = last_ff;

   // Checks
   `ASSERT_ALWAYS(a_border_zero, clock, reset,
      !(rsp_tvalid && kept_ff != 16'd0) || (orow_ff != 10'd0 && ocol_ff != 10'd0))
   `ASSERT_NEXT(a_accept_loads, clock, reset, req_tvalid && req_tready, s1_valid_ff)
   `ASSERT_ALWAYS(a_stall_blocks, clock, reset,
      !(out_valid_ff && !rsp_tready && s1_valid_ff) || !req_tready)

endmodule
